>>> hdl/maub_pkg.sv
// Shared types and constants for the majority-ack uniform broadcast block.
package maub_pkg;

	localparam int MAX_PROCESSES_DEF = 16;
	localparam int SEQ_SLOTS_DEF     = 1024;

	localparam int SRC_W      = 4;
	localparam int SEQ_W      = 10;
	localparam int ID_W       = 4;
	localparam int PC_W       = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int DATA_W     = 24;
	localparam int IN_USER_W  = 1;
	localparam int OUT_USER_W = 3;
	localparam int FIELD_W    = SRC_W + SEQ_W + ID_W;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [PC_W-1:0] PC_RESET  = PC_W'(16);
	localparam logic [ID_W-1:0] OWN_RESET = '0;

	localparam logic OP_RECEIVE   = 1'b0;
	localparam logic OP_BROADCAST = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROCESS_COUNT = 2'd0,
		REG_OWN_ID        = 2'd1
	} reg_idx_t;

	// classified item as it sits in the queue
	typedef struct packed {
		logic             op;
		logic             error;
		logic [SRC_W-1:0] src;
		logic [SEQ_W-1:0] seq;
		logic [ID_W-1:0]  snd;
	} item_t;

	// result flags, send in bit 0
	typedef struct packed {
		logic error;
		logic deliver;
		logic send;
	} flags_t;

	// result payload, source in the low bits
	typedef struct packed {
		logic [ID_W-1:0]  sender;
		logic [SEQ_W-1:0] seq;
		logic [SRC_W-1:0] source;
	} res_data_t;

endpackage

>>> hdl/majority_ack_uniform_broadcast.sv
// Top level: majority-ack uniform reliable broadcast slot table.
//
//  channel | signals                              | direction | word
//  --------+--------------------------------------+-----------+-------------------------------
//  s_      | s_tvalid s_tready s_tdata s_tuser    | in        | packet or broadcast request
//  m_      | m_tvalid m_tready m_tdata m_tuser    | out       | one result per input word
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data| in        | register write
//
// Each word takes a table read in the back end, then update and write-back once the result register is free.
// The back end takes a new word only after the last one has been written back.
// A 4-deep queue lets input words keep arriving while a result waits on m_tready.
// After reset a clearing sweep zeroes the table, one slot a cycle (16384 slots at the
// default sizes); no input word is taken until it finishes, config writes are always taken.
module majority_ack_uniform_broadcast #(
	parameter int MAX_PROCESSES = maub_pkg::MAX_PROCESSES_DEF,
	parameter int SEQ_SLOTS     = maub_pkg::SEQ_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [maub_pkg::DATA_W-1:0]     s_tdata,   // src, seq_num, sender_id
	input  logic [maub_pkg::IN_USER_W-1:0]  s_tuser,   // operation
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [maub_pkg::DATA_W-1:0]     m_tdata,   // out_source, out_seq, out_sender
	output logic [maub_pkg::OUT_USER_W-1:0] m_tuser,   // send, deliver, error
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [maub_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [maub_pkg::CFG_DATA_W-1:0] cfg_data
);
	import maub_pkg::*;

	logic [PC_W-1:0] process_count_q;
	logic [ID_W-1:0] own_id_q;
	logic            push;
	item_t           push_item;
	logic            q_full;
	logic            q_valid;
	item_t           q_head;
	logic            q_pop;
	logic            clr_done;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			process_count_q <= PC_RESET;
			own_id_q        <= OWN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PROCESS_COUNT: process_count_q <= cfg_data[PC_W-1:0];
				REG_OWN_ID:        own_id_q        <= cfg_data[ID_W-1:0];
				default: ;
			endcase
		end
	end

	maub_front #(
		.MAX_PROCESSES (MAX_PROCESSES),
		.SEQ_SLOTS     (SEQ_SLOTS)
	) u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.clr_done  (clr_done),
		.push      (push),
		.push_item (push_item)
	);

	maub_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	maub_back #(
		.MAX_PROCESSES (MAX_PROCESSES),
		.SEQ_SLOTS     (SEQ_SLOTS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_head),
		.q_pop         (q_pop),
		.process_count (process_count_q),
		.own_id        (own_id_q),
		.clr_done      (clr_done),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser)
	);

endmodule

>>> hdl/maub_front.sv
// Input side: accepts words, checks table bounds and classifies them for the queue.
module maub_front #(
	parameter int MAX_PROCESSES = maub_pkg::MAX_PROCESSES_DEF,
	parameter int SEQ_SLOTS     = maub_pkg::SEQ_SLOTS_DEF
) (
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [maub_pkg::DATA_W-1:0]    s_tdata,   // src, seq_num, sender_id, zero pad
	input  logic [maub_pkg::IN_USER_W-1:0] s_tuser,   // operation
	input  logic                           q_full,
	input  logic                           clr_done,
	output logic                           push,
	output maub_pkg::item_t                push_item
);
	import maub_pkg::*;

	logic [SRC_W-1:0] src;
	logic [SEQ_W-1:0] seq;
	logic [ID_W-1:0]  snd;
	logic             op;
	logic             bad;

	always_comb begin
		src = s_tdata[SRC_W-1:0];
		seq = s_tdata[SRC_W +: SEQ_W];
		snd = s_tdata[SRC_W+SEQ_W +: ID_W];
		op  = s_tuser[0];
		// sender only matters for received packets
		bad = (int'(src) >= MAX_PROCESSES) || (int'(seq) >= SEQ_SLOTS) ||
			((op == OP_RECEIVE) && (int'(snd) >= MAX_PROCESSES));
		push_item.op    = op;
		push_item.error = bad;
		push_item.src   = src;
		push_item.seq   = seq;
		push_item.snd   = snd;
	end

	assign s_tready = clr_done && !q_full;
	assign push     = s_tvalid && s_tready;

endmodule

>>> hdl/maub_queue.sv
// Short FIFO between the classifying front and the table back end.
module maub_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  maub_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output maub_pkg::item_t head
);
	import maub_pkg::*;

	item_t             entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_item;
	end

endmodule

>>> hdl/maub_back.sv
// Back end: slot table, clearing sweep, read-modify-write per item and result register.
module maub_back #(
	parameter int MAX_PROCESSES = maub_pkg::MAX_PROCESSES_DEF,
	parameter int SEQ_SLOTS     = maub_pkg::SEQ_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	input  maub_pkg::item_t                 q_item,
	output logic                            q_pop,
	input  logic [maub_pkg::PC_W-1:0]       process_count,
	input  logic [maub_pkg::ID_W-1:0]       own_id,
	output logic                            clr_done,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [maub_pkg::DATA_W-1:0]     m_tdata,
	output logic [maub_pkg::OUT_USER_W-1:0] m_tuser
);
	import maub_pkg::*;

	// only slots reachable through the 4-bit source and 10-bit sequence fields
	localparam int SRC_N  = (MAX_PROCESSES < (1 << SRC_W)) ? MAX_PROCESSES : (1 << SRC_W);
	localparam int SEQ_N  = (SEQ_SLOTS < (1 << SEQ_W)) ? SEQ_SLOTS : (1 << SEQ_W);
	localparam int SRC_AW = $clog2(SRC_N);
	localparam int SEQ_AW = $clog2(SEQ_N);
	localparam int AW     = SRC_AW + SEQ_AW;
	localparam int DEPTH  = 1 << AW;
	localparam int PW     = MAX_PROCESSES;
	localparam int CW     = $clog2(MAX_PROCESSES + 1);
	localparam int EW     = PW + CW + 2;
	localparam int PD     = PW + CW;   // pending bit position
	localparam int DD     = PW + CW + 1;   // delivered bit position

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_LOOK  = 3'b100
	} state_t;

	state_t          state_q;
	state_t          state_d;
	logic [AW-1:0]   clr_addr_q;
	logic [EW-1:0]   slot_mem_q [DEPTH];
	logic [EW-1:0]   rd_data_q;
	item_t           cur_q;
	logic            m_valid_q;
	flags_t          m_flags_q;
	res_data_t       m_data_q;

	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [EW-1:0]   wr_data;
	logic            out_free;
	logic            load;
	logic [PW-1:0]   bitmap;
	logic [PW-1:0]   set_mask;
	logic [CW-1:0]   cnt;
	logic [CW-1:0]   cnt_new;
	logic            pend;
	logic            dlv;
	logic            pend_mid;
	logic            send;
	logic            deliver;
	logic [EW-1:0]   new_entry;
	flags_t          res_flags;
	res_data_t       res_data;

	assign clr_done = (state_q != ST_CLEAR);
	assign out_free = !m_valid_q || m_tready;
	assign rd_en    = (state_q == ST_IDLE) && q_valid;
	assign q_pop    = rd_en;
	assign rd_addr  = {q_item.src[SRC_AW-1:0], q_item.seq[SEQ_AW-1:0]};
	assign load     = (state_q == ST_LOOK) && out_free;

	always_comb begin
		bitmap   = rd_data_q[PW-1:0];
		cnt      = rd_data_q[PW +: CW];
		pend     = rd_data_q[PD];
		dlv      = rd_data_q[DD];
		set_mask = PW'(1) << cur_q.snd;
		send     = 1'b0;
		deliver  = 1'b0;
		cnt_new  = cnt;
		pend_mid = pend;
		new_entry = rd_data_q;
		if (cur_q.op == OP_BROADCAST) begin
			send = 1'b1;
			new_entry[PD] = 1'b1;
		end else begin
			// a repeated ack leaves the count alone
			cnt_new  = cnt + CW'((bitmap & set_mask) == '0);
			send     = !pend && !dlv;
			pend_mid = pend || send;
			deliver  = (8'(cnt_new) > 8'(process_count >> 1)) && pend_mid && !dlv;
			new_entry = {dlv || deliver, pend_mid && !deliver, cnt_new, bitmap | set_mask};
		end

		res_flags.error   = cur_q.error;
		res_flags.send    = send && !cur_q.error;
		res_flags.deliver = deliver && !cur_q.error;
		if (cur_q.error) begin
			res_data = '0;
		end else begin
			res_data.source = cur_q.src;
			res_data.seq    = cur_q.seq;
			res_data.sender = send ? own_id : cur_q.snd;
		end
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else begin
			wr_en   = load && !cur_q.error;
			wr_addr = {cur_q.src[SRC_AW-1:0], cur_q.seq[SEQ_AW-1:0]};
			wr_data = new_entry;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == '1)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (q_valid)
					state_d = ST_LOOK;
			end
			ST_LOOK: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_addr_q <= clr_addr_q + 1'b1;
			if (load)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			slot_mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= slot_mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			cur_q <= q_item;
		if (load) begin
			m_flags_q <= res_flags;
			m_data_q  <= res_data;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_flags_q;
	assign m_tdata  = {(DATA_W - FIELD_W)'(0), m_data_q};

	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !q_pop)
		else $error("queue popped during clearing sweep");

	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK && !out_free) |=> (state_q == ST_LOOK))
		else $error("item left lookup while result register full");

	a_error_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(load && res_flags.error) |-> (!res_flags.send && !res_flags.deliver && !wr_en))
		else $error("out-of-table item caused action");

	a_deliver_on_receive: assert property (@(posedge clk) disable iff (!arst_n)
		(load && res_flags.deliver) |-> (cur_q.op == OP_RECEIVE))
		else $error("delivery on a local broadcast");

endmodule

>>> dv/maub_outcome_checker.sv
// Checker for the broadcast slot table: tracks acks, predicts each result word, compares.
module maub_outcome_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [maub_pkg::DATA_W-1:0]     s_tdata,
	input  logic [maub_pkg::IN_USER_W-1:0]  s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [maub_pkg::DATA_W-1:0]     m_tdata,
	input  logic [maub_pkg::OUT_USER_W-1:0] m_tuser,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [maub_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [maub_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              failures,
	output int                              awaited,
	output int                              relays,
	output int                              deliveries
);
	import maub_pkg::*;

	localparam int SLOTS = MAX_PROCESSES_DEF * SEQ_SLOTS_DEF;

	typedef struct packed {
		flags_t    flags;
		res_data_t data;
	} outcome_t;

	logic [MAX_PROCESSES_DEF-1:0] ack_map [SLOTS];
	bit                           slot_pending [SLOTS];
	bit                           slot_delivered [SLOTS];
	logic [PC_W-1:0]              group_size;
	logic [ID_W-1:0]              self_id;
	outcome_t                     awaited_q [$];
	int                           fail_tally;
	int                           result_no;
	int                           relay_tally;
	int                           deliver_tally;

	task automatic flag_mismatch(string what);
		$display("%0t: result %0d: %s", $time, result_no, what);
		fail_tally++;
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want)
			flag_mismatch($sformatf("%s is %0d, predicted %0d", name, got, want));
	endtask

	// applies one accepted word to the slot table and returns the result it must produce
	function automatic outcome_t relay_or_deliver(logic op, res_data_t w);
		outcome_t o;
		int       slot;
		o = '0;
		if (w.source >= MAX_PROCESSES_DEF || w.seq >= SEQ_SLOTS_DEF ||
		    (op == OP_RECEIVE && w.sender >= MAX_PROCESSES_DEF)) begin
			o.flags.error = 1'b1;
			return o;
		end
		slot = int'(w.source) * SEQ_SLOTS_DEF + int'(w.seq);
		if (op == OP_BROADCAST) begin
			slot_pending[slot] = 1'b1;
			o.flags.send = 1'b1;
		end else begin
			ack_map[slot][w.sender] = 1'b1;
			if (!slot_pending[slot] && !slot_delivered[slot]) begin
				slot_pending[slot] = 1'b1;
				o.flags.send = 1'b1;
			end
			// strict majority of the configured group, integer halving
			if ($countones(ack_map[slot]) > int'(group_size / 2) &&
			    slot_pending[slot] && !slot_delivered[slot]) begin
				slot_delivered[slot] = 1'b1;
				slot_pending[slot] = 1'b0;
				o.flags.deliver = 1'b1;
			end
		end
		o.data.source = w.source;
		o.data.seq = w.seq;
		o.data.sender = o.flags.send ? self_id : w.sender;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t  got;
		outcome_t  want;
		res_data_t w;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				ack_map[i] = '0;
				slot_pending[i] = 1'b0;
				slot_delivered[i] = 1'b0;
			end
			group_size = PC_RESET;
			self_id = OWN_RESET;
			awaited_q.delete();
			fail_tally = 0;
			result_no = 0;
			relay_tally = 0;
			deliver_tally = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PROCESS_COUNT: group_size = cfg_data[PC_W-1:0];
					REG_OWN_ID:        self_id = cfg_data[ID_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.flags = flags_t'(m_tuser);
				got.data = res_data_t'(m_tdata[FIELD_W-1:0]);
				if (awaited_q.size() == 0) begin
					flag_mismatch("result word arrived with nothing awaited");
				end else begin
					want = awaited_q.pop_front();
					check_field("send", got.flags.send, want.flags.send);
					check_field("deliver", got.flags.deliver, want.flags.deliver);
					check_field("error", got.flags.error, want.flags.error);
					check_field("out_source", got.data.source, want.data.source);
					check_field("out_seq", got.data.seq, want.data.seq);
					check_field("out_sender", got.data.sender, want.data.sender);
				end
				relay_tally += got.flags.send;
				deliver_tally += got.flags.deliver;
				result_no++;
			end
			if (s_tvalid && s_tready) begin
				w = res_data_t'(s_tdata[FIELD_W-1:0]);
				awaited_q.insert(awaited_q.size(), relay_or_deliver(s_tuser[0], w));
			end
		end
		failures <= fail_tally;
		awaited <= awaited_q.size();
		relays <= relay_tally;
		deliveries <= deliver_tally;
	end

endmodule

>>> dv/tb_majority_ack_uniform_broadcast.sv
// Testbench top: drives packets, broadcasts and register writes, and gives the verdict.
module tb_majority_ack_uniform_broadcast;
	import maub_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int PHASES       = 8;
	localparam int RANDOM_WORDS = 640;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [DATA_W-1:0]     s_tdata = '0;
	logic [IN_USER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b1;
	logic [DATA_W-1:0]     m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int failures;
	int awaited;
	int relays;
	int deliveries;
	int sender_idle_pct = 0;
	int stall_pct = 0;
	int words_sent = 0;
	int cfg_writes = 0;

	logic [4:0] pc_plan  [PHASES] = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd2, 5'd5, 5'd3, 5'd9};
	logic [4:0] own_plan [PHASES] = '{5'd15, 5'd0, 5'd31, 5'd16, 5'd9, 5'd3, 5'd12, 5'd6};

	majority_ack_uniform_broadcast DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	maub_outcome_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.failures  (failures),
		.awaited   (awaited),
		.relays    (relays),
		.deliveries(deliveries)
	);

	initial forever #5 clk = ~clk;

	initial begin
		#3_000_000;
		$display("Run timed out with %0d results still awaited", awaited);
		$display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic idle_gap();
		int gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// valid stays high into the next word unless an idle gap or a drain drops it
	task automatic push_word(logic op, int src, int seq, int snd);
		res_data_t w;
		w.source = SRC_W'(src);
		w.seq = SEQ_W'(seq);
		w.sender = ID_W'(snd);
		s_tvalid <= 1'b1;
		s_tdata <= DATA_W'(w);
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		idle_gap();
	endtask

	task automatic drain();
		if (s_tvalid)
			s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited != 0)
			@(posedge clk);
	endtask

	task automatic cfg_word(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_writes++;
	endtask

	task automatic configure(logic [4:0] pc, logic [4:0] own, bit poke_unused);
		drain();
		cfg_word(REG_PROCESS_COUNT, pc);
		cfg_word(REG_OWN_ID, own);
		if (poke_unused)
			cfg_word(REG_UNUSED, CFG_DATA_W'($urandom_range(31)));
		cfg_valid <= 1'b0;
	endtask

	// stray traffic, biased toward a few low slots so it lands on live entries
	task automatic noise_word();
		int src;
		int seq;
		src = $urandom_range(1) ? $urandom_range(1) : $urandom_range(15);
		seq = $urandom_range(1) ? $urandom_range(3) : $urandom_range(1023);
		push_word(logic'($urandom_range(1)), src, seq, $urandom_range(15));
	endtask

	// one message life: optional local broadcast, acks from distinct peers, some repeats
	task automatic slot_episode();
		int src;
		int seq;
		int order [16];
		int k;
		int j;
		int t;
		src = $urandom_range(15);
		seq = $urandom_range(1023);
		for (int i = 0; i < 16; i++)
			order[i] = i;
		for (int i = 15; i > 0; i--) begin
			j = $urandom_range(i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		k = ($urandom_range(3) == 0) ? 16 : $urandom_range(1, 16);
		if ($urandom_range(1))
			push_word(OP_BROADCAST, src, seq, $urandom_range(15));
		for (int i = 0; i < k; i++) begin
			if ($urandom_range(9) == 0)
				noise_word();
			if (i > 0 && $urandom_range(9) == 0)
				push_word(OP_RECEIVE, src, seq, order[$urandom_range(i - 1)]);
			push_word(OP_RECEIVE, src, seq, order[i]);
		end
		if ($urandom_range(4) == 0)
			push_word(OP_BROADCAST, src, seq, $urandom_range(15));
	endtask

	initial begin
		int goal;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: majority of three needs two acks
		configure(5'd3, 5'd5, 1'b0);
		push_word(OP_BROADCAST, 0, 0, 15);
		push_word(OP_RECEIVE, 0, 0, 0);
		push_word(OP_RECEIVE, 0, 0, 0);      // repeated ack counts once
		push_word(OP_RECEIVE, 0, 0, 15);     // delivers
		push_word(OP_BROADCAST, 0, 0, 0);    // re-broadcast of a delivered slot
		push_word(OP_RECEIVE, 0, 0, 7);      // no second delivery
		push_word(OP_RECEIVE, 15, 1023, 15); // first sight: relay
		push_word(OP_RECEIVE, 15, 1023, 3);
		push_word(OP_RECEIVE, 15, 1023, 9);
		push_word(OP_RECEIVE, 5, 10'h2AA, 10);
		push_word(OP_RECEIVE, 10, 10'h155, 5);
		// zero group size: a single ack is a majority, relay and deliver together
		configure(5'd0, 5'd10, 1'b0);
		push_word(OP_RECEIVE, 9, 512, 2);
		push_word(OP_BROADCAST, 3, 7, 0);
		push_word(OP_RECEIVE, 3, 7, 4);
		configure(5'd1, 5'd31, 1'b0);
		push_word(OP_RECEIVE, 1, 1, 1);
		push_word(OP_RECEIVE, 1, 1, 14);

		for (int p = 0; p < PHASES; p++) begin
			configure(pc_plan[p], own_plan[p], p == 3);
			case (p % 4)
				0: begin sender_idle_pct = 0;  stall_pct = 0;  end
				1: begin sender_idle_pct = 88; stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  stall_pct = 88; end
				default: begin sender_idle_pct = 12; stall_pct = 12; end
			endcase
			goal = words_sent + RANDOM_WORDS / PHASES;
			while (words_sent < goal) begin
				if ($urandom_range(4) == 0)
					noise_word();
				else
					slot_episode();
				if ($urandom_range(29) == 0)
					drain();
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d words over %0d traffic phases with %0d register writes",
			words_sent, PHASES, cfg_writes);
		$display("Block sent or relayed %0d words and delivered %0d messages",
			relays, deliveries);
		if (failures == 0 && awaited == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
